FILE: rtl/q4_0_block_dequantizer_assert.svh
// Assertion macros for the checker file.
`ifndef Q4_0_BLOCK_DEQUANTIZER_ASSERT_SVH
`define Q4_0_BLOCK_DEQUANTIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
		else $error("assertion failed");
// Condition that must hold in the cycle after the trigger, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("assertion failed");
`endif

FILE: rtl/q4d_pkg.sv
package q4d_pkg;
	localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
	localparam logic [31:0] INF_BITS  = 32'h7F800000;
	localparam logic [4:0]  EXP_MAX   = 5'h1F;

	// fp32 bits of (code - 8) * half scale; product is exact.
	function automatic logic [31:0] weight_bits(input logic [3:0] code, input logic [15:0] half);
		logic       s;
		logic [4:0] e;
		logic [9:0] m;
		logic       neg;
		logic [3:0] mag;
		logic [10:0] sig;
		logic [14:0] p;
		logic [3:0] top;
		logic [7:0] ex;
		logic [22:0] frac;
		logic [31:0] r;
		s = half[15];
		e = half[14:10];
		m = half[9:0];
		neg = ~code[3];
		mag = neg ? (4'd8 - code) : (code - 4'd8);
		sig = (e == 5'd0) ? {1'b0, m} : {1'b1, m};
		p = 15'(mag * sig);
		top = 4'd0;
		for (int i = 1; i < 14; i++) begin
			if (p[i]) top = 4'(i);
		end
		// Exponent: top + pw + 127, pw = -24 subnormal, e - 25 normal.
		ex = (e == 5'd0) ? 8'(top + 8'd103) : 8'(top + {3'b0, e} + 8'd102);
		frac = 23'((32'(p) << (5'd23 - 5'(top))) & 32'h7FFFFF);
		if (e == EXP_MAX) begin
			if (m != 10'd0 || mag == 4'd0) r = QNAN_BITS;
			else r = {s ^ neg, INF_BITS[30:0]};
		end else if (p == 15'd0) begin
			r = {s ^ neg, 31'd0};
		end else begin
			r = {s ^ neg, ex, frac};
		end
		return r;
	endfunction
endpackage

FILE: rtl/q4d_if.sv
interface q4d_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] scale_bits;
	logic [63:0] packed_first_half;
	logic [63:0] packed_second_half;
	logic        final_block;
	modport source(output valid, scale_bits, packed_first_half, packed_second_half,
		final_block, input ready);
	modport sink(input valid, scale_bits, packed_first_half, packed_second_half,
		final_block, output ready);
endinterface

interface q4d_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  byte_index;
	logic [31:0] weight_low_nibble;
	logic [31:0] weight_high_nibble;
	logic        end_of_block;
	logic        end_of_stream;
	modport source(output valid, byte_index, weight_low_nibble, weight_high_nibble,
		end_of_block, end_of_stream, input ready);
	modport sink(input valid, byte_index, weight_low_nibble, weight_high_nibble,
		end_of_block, end_of_stream, output ready);
endinterface

FILE: rtl/q4_0_block_dequantizer.sv
// Q4_0 block dequantizer. Each input item is one block (half-precision scale and sixteen
// packed bytes); it yields sixteen result items, one per packed byte j in order, each
// carrying the exact fp32 weights for index j (low nibble) and j+16 (high nibble).
// The result channel sets the rate, and a sink that is not ready stalls the walk. A
// block is held in an input register while a byte counter walks it; the next
// block is accepted in the cycle that the last byte of the current one is decoded, so
// blocks follow back to back. Results pass through one output register.
module q4_0_block_dequantizer import q4d_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	q4d_in_if.sink  in_ch,
	q4d_out_if.source out_ch
);
	logic         full_q;
	logic [3:0]   idx_q;
	logic [15:0]  scale_q;
	logic [127:0] bytes_q;
	logic         fin_q;
	logic         ovalid_q;
	logic         advance;
	logic         take;
	logic [7:0]   cur_byte;

	// A result moves into the output register when it is empty or being drained.
	assign advance = full_q && (!ovalid_q || out_ch.ready);
	// Accept a block when none is held or the held one issues its last byte now.
	assign in_ch.ready = !full_q || (advance && idx_q == 4'd15);
	assign take = in_ch.valid && in_ch.ready;
	assign cur_byte = bytes_q[{idx_q, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q   <= 1'b0;
			idx_q    <= 4'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (advance) idx_q <= idx_q + 4'd1;
			if (take) full_q <= 1'b1;
			else if (advance && idx_q == 4'd15) full_q <= 1'b0;
			if (advance) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			scale_q <= in_ch.scale_bits;
			bytes_q <= {in_ch.packed_second_half, in_ch.packed_first_half};
			fin_q   <= in_ch.final_block;
		end
		if (advance) begin
			out_ch.byte_index         <= idx_q;
			out_ch.weight_low_nibble  <= weight_bits(cur_byte[3:0], scale_q);
			out_ch.weight_high_nibble <= weight_bits(cur_byte[7:4], scale_q);
			out_ch.end_of_block       <= (idx_q == 4'd15);
			out_ch.end_of_stream      <= (idx_q == 4'd15) && fin_q;
		end
	end

	assign out_ch.valid = ovalid_q;
endmodule

FILE: rtl/q4d_checker.sv
`include "q4_0_block_dequantizer_assert.svh"
module q4d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] byte_index,
	input logic       end_of_block,
	input logic       end_of_stream
);
	// End of block marks exactly the last byte.
	`ASSERT_IMPL(a_eob, clk, arst_n, out_valid |-> (end_of_block == (byte_index == 4'd15)))
	// End of stream only on an end of block.
	`ASSERT_IMPL(a_eos, clk, arst_n, (out_valid && end_of_stream) |-> end_of_block)
	// A result shown directly after a taken one carries the following index.
	`ASSERT_NEXT(a_seq, clk, arst_n, out_valid && out_ready,
		!out_valid || byte_index == $past(byte_index) + 4'd1)
endmodule

bind q4_0_block_dequantizer q4d_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.byte_index(out_ch.byte_index), .end_of_block(out_ch.end_of_block),
	.end_of_stream(out_ch.end_of_stream)
);
